// ===== hw/rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg
// shared constants, register codes and stage types of the stepped color map
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_STEPS    = 256;

    localparam int SW         = SAMPLE_WIDTH;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int STEP_CFG_W = 9;
    localparam int STEP_OUT_W = 8;
    localparam int CFG_DATA_W = (SW > COLOR_W) ? SW : COLOR_W;
    localparam int REG_IDX_W  = 3;

    // clamped step count and step index
    localparam int STW = $clog2(MAX_STEPS + 1);
    localparam int KW  = $clog2(MAX_STEPS);
    localparam int K2W = KW + 1;

    // position datapath
    localparam int DW      = SW + 1;
    localparam int BW      = SW + 1;
    localparam int DEN_W   = SW + 1;
    localparam int QW      = STW;
    localparam int NUM_W   = BW + STW;
    localparam int QBITS   = 3;
    localparam int QSTAGES = (QW + QBITS - 1) / QBITS;

    // channel datapath
    localparam int WSUM_W  = CHAN_W + KW;
    localparam int CBITS   = 4;
    localparam int CSTAGES = (CHAN_W + CBITS - 1) / CBITS;

    localparam logic [REG_IDX_W-1:0] REG_VALUE_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_MID  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MID  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_HIGH = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 3'd6;

    localparam logic [SW-1:0]         VALUE_LOW_RST  = SW'(0);
    localparam logic [SW-1:0]         VALUE_MID_RST  = SW'(16384);
    localparam logic [SW-1:0]         VALUE_HIGH_RST = SW'(32767);
    localparam logic [COLOR_W-1:0]    COLOR_LOW_RST  = 24'h0000FF;
    localparam logic [COLOR_W-1:0]    COLOR_MID_RST  = 24'h00FF00;
    localparam logic [COLOR_W-1:0]    COLOR_HIGH_RST = 24'hFF0000;
    localparam logic [STEP_CFG_W-1:0] STEP_COUNT_RST = 9'd16;

    typedef struct packed {
        logic signed [SW-1:0] value_low;
        logic signed [SW-1:0] value_mid;
        logic signed [SW-1:0] value_high;
        logic [COLOR_W-1:0]   color_low;
        logic [COLOR_W-1:0]   color_mid;
        logic [COLOR_W-1:0]   color_high;
        logic [STW-1:0]       steps;
        logic [KW-1:0]        steps_m1;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } pos_t;

    typedef struct packed {
        logic          valid;
        logic [QW-1:0] quo;
    } quo_t;

endpackage

// ===== hw/rtl/scm_cfg.sv =====
// ----------------------------------------------------------------------------
// scm_cfg
// configuration register file with clamped step count
// ----------------------------------------------------------------------------
module scm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [scm_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]  wr_data,
    output scm_pkg::cfg_t                   cfg
);
    import scm_pkg::*;

    logic [SW-1:0]         value_low_reg;
    logic [SW-1:0]         value_mid_reg;
    logic [SW-1:0]         value_high_reg;
    logic [COLOR_W-1:0]    color_low_reg;
    logic [COLOR_W-1:0]    color_mid_reg;
    logic [COLOR_W-1:0]    color_high_reg;
    logic [STEP_CFG_W-1:0] step_count_reg;
    logic [STW-1:0]        steps;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_low_reg  <= VALUE_LOW_RST;
            value_mid_reg  <= VALUE_MID_RST;
            value_high_reg <= VALUE_HIGH_RST;
            color_low_reg  <= COLOR_LOW_RST;
            color_mid_reg  <= COLOR_MID_RST;
            color_high_reg <= COLOR_HIGH_RST;
            step_count_reg <= STEP_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_VALUE_LOW:  value_low_reg  <= wr_data[SW-1:0];
                REG_VALUE_MID:  value_mid_reg  <= wr_data[SW-1:0];
                REG_VALUE_HIGH: value_high_reg <= wr_data[SW-1:0];
                REG_COLOR_LOW:  color_low_reg  <= wr_data[COLOR_W-1:0];
                REG_COLOR_MID:  color_mid_reg  <= wr_data[COLOR_W-1:0];
                REG_COLOR_HIGH: color_high_reg <= wr_data[COLOR_W-1:0];
                REG_STEP_COUNT: step_count_reg <= wr_data[STEP_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (step_count_reg < STEP_CFG_W'(2))
            steps = STW'(2);
        else if (32'(step_count_reg) > MAX_STEPS)
            steps = STW'(MAX_STEPS);
        else
            steps = STW'(step_count_reg);
    end

    always_comb
    begin
        cfg.value_low  = $signed(value_low_reg);
        cfg.value_mid  = $signed(value_mid_reg);
        cfg.value_high = $signed(value_high_reg);
        cfg.color_low  = color_low_reg;
        cfg.color_mid  = color_mid_reg;
        cfg.color_high = color_high_reg;
        cfg.steps      = steps;
        cfg.steps_m1   = KW'(steps - STW'(1));
    end

endmodule

// ===== hw/rtl/scm_pos.sv =====
// ----------------------------------------------------------------------------
// scm_pos
// clamp, segment select and scaled position, four register stages
// ----------------------------------------------------------------------------
module scm_pos (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [scm_pkg::SW-1:0] sample,
    input  scm_pkg::cfg_t                cfg,
    output scm_pkg::pos_t                pos
);
    import scm_pkg::*;

    logic signed [SW-1:0] x_clamp;
    logic                 v1_reg;
    logic signed [SW-1:0] x1_reg;

    logic                 seg;
    logic signed [SW-1:0] seg_a;
    logic signed [SW-1:0] seg_b;
    logic                 v2_reg;
    logic                 seg2_reg;
    logic signed [DW-1:0] d2_reg;
    logic signed [DW-1:0] n2_reg;

    logic [SW-1:0]        d_sat;
    logic [SW-1:0]        n_sat;
    logic [BW-1:0]        base;
    logic                 v3_reg;
    logic [BW-1:0]        base3_reg;
    logic [DEN_W-1:0]     den3_reg;

    logic                 v4_reg;
    logic [NUM_W-1:0]     num4_reg;
    logic [DEN_W-1:0]     den4_reg;

    // clamp to [low, high]; when unordered, a sample below low gives low, any other high
    always_comb
    begin
        if (sample < cfg.value_low)
            x_clamp = cfg.value_low;
        else if (cfg.value_high < sample)
            x_clamp = cfg.value_high;
        else
            x_clamp = sample;
    end

    // segment endpoints
    always_comb
    begin
        seg   = !(x1_reg < cfg.value_mid);
        seg_a = seg ? cfg.value_mid : cfg.value_low;
        seg_b = seg ? cfg.value_high : cfg.value_mid;
    end

    // empty segment and fraction saturation
    always_comb
    begin
        if (d2_reg[DW-1] || (d2_reg == '0))
        begin
            d_sat = SW'(1);
            n_sat = '0;
        end
        else
        begin
            d_sat = d2_reg[SW-1:0];
            if (n2_reg[DW-1])
                n_sat = '0;
            else if (n2_reg > d2_reg)
                n_sat = d2_reg[SW-1:0];
            else
                n_sat = n2_reg[SW-1:0];
        end
        base = seg2_reg ? (BW'(d_sat) + BW'(n_sat)) : BW'(n_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x_clamp;
        seg2_reg  <= seg;
        d2_reg    <= $signed({seg_b[SW-1], seg_b}) - $signed({seg_a[SW-1], seg_a});
        n2_reg    <= $signed({x1_reg[SW-1], x1_reg}) - $signed({seg_a[SW-1], seg_a});
        base3_reg <= base;
        den3_reg  <= {d_sat, 1'b0};
        num4_reg  <= NUM_W'(base3_reg) * NUM_W'(cfg.steps);
        den4_reg  <= den3_reg;
    end

    always_comb
    begin
        pos.valid = v4_reg;
        pos.num   = num4_reg;
        pos.den   = den4_reg;
    end

endmodule

// ===== hw/rtl/scm_qdiv.sv =====
// ----------------------------------------------------------------------------
// scm_qdiv
// pipelined restoring divider giving the raw step index
// ----------------------------------------------------------------------------
module scm_qdiv (
    input  logic          clk,
    input  logic          rst_n,
    input  scm_pkg::pos_t pos,
    output scm_pkg::quo_t quo
);
    import scm_pkg::*;

    logic             v_reg    [QSTAGES];
    logic [NUM_W-1:0] rem_reg  [QSTAGES];
    logic [DEN_W-1:0] den_reg  [QSTAGES];
    logic [QW-1:0]    quo_reg  [QSTAGES];

    logic             v_next   [QSTAGES];
    logic [NUM_W-1:0] rem_next [QSTAGES];
    logic [DEN_W-1:0] den_next [QSTAGES];
    logic [QW-1:0]    quo_next [QSTAGES];

    always_comb
    begin
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] trial;
        logic [QW-1:0]    q;
        logic [DEN_W-1:0] den;
        for (int s = 0; s < QSTAGES; s++)
        begin
            if (s == 0)
            begin
                v_next[s] = pos.valid;
                rem       = pos.num;
                den       = pos.den;
                q         = '0;
            end
            else
            begin
                v_next[s] = v_reg[s-1];
                rem       = rem_reg[s-1];
                den       = den_reg[s-1];
                q         = quo_reg[s-1];
            end
            // quotient bits from the top, three per stage
            for (int i = 0; i < QBITS; i++)
            begin
                if (s * QBITS + i < QW)
                begin
                    trial = NUM_W'(den) << (QW - 1 - s * QBITS - i);
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        q   = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[QW-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = rem;
            den_next[s] = den;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QSTAGES; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < QSTAGES; s++)
                v_reg[s] <= v_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QSTAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    always_comb
    begin
        quo.valid = v_reg[QSTAGES-1];
        quo.quo   = quo_reg[QSTAGES-1];
    end

endmodule

// ===== hw/rtl/scm_blend.sv =====
// ----------------------------------------------------------------------------
// scm_blend
// step index clamp, blend weights, channel sums and pipelined channel divide
// ----------------------------------------------------------------------------
module scm_blend (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scm_pkg::quo_t                   quo,
    input  scm_pkg::cfg_t                   cfg,
    output logic                            done,
    output logic [scm_pkg::CHAN_W-1:0]      red,
    output logic [scm_pkg::CHAN_W-1:0]      green,
    output logic [scm_pkg::CHAN_W-1:0]      blue,
    output logic [scm_pkg::STEP_OUT_W-1:0]  step_index
);
    import scm_pkg::*;

    logic [KW-1:0]     k_a;
    logic [K2W-1:0]    k2;
    logic [K2W-1:0]    s1x;
    logic              upper;
    logic [KW-1:0]     w1;
    logic              va_reg;
    logic [KW-1:0]     ka_reg;
    logic              upper_a_reg;
    logic [KW-1:0]     w0_a_reg;
    logic [KW-1:0]     w1_a_reg;

    logic [COLOR_W-1:0] c0;
    logic [COLOR_W-1:0] c1;
    logic [WSUM_W-1:0]  sum_b_next [NCHAN];
    logic               vb_reg;
    logic [KW-1:0]      kb_reg;
    logic [WSUM_W-1:0]  sum_b_reg  [NCHAN];

    logic               cv_reg    [CSTAGES];
    logic [KW-1:0]      ck_reg    [CSTAGES];
    logic [WSUM_W-1:0]  crem_reg  [CSTAGES][NCHAN];
    logic [CHAN_W-1:0]  cquo_reg  [CSTAGES][NCHAN];
    logic               cv_next   [CSTAGES];
    logic [KW-1:0]      ck_next   [CSTAGES];
    logic [WSUM_W-1:0]  crem_next [CSTAGES][NCHAN];
    logic [CHAN_W-1:0]  cquo_next [CSTAGES][NCHAN];

    // step index clamp and blend weights
    always_comb
    begin
        k_a = (quo.quo > QW'(cfg.steps_m1)) ? cfg.steps_m1 : KW'(quo.quo);
        k2  = {k_a, 1'b0};
        s1x = K2W'(cfg.steps_m1);
        if (k2 < s1x)
        begin
            upper = 1'b0;
            w1    = KW'(k2);
        end
        else
        begin
            upper = 1'b1;
            w1    = KW'(k2 - s1x);
        end
    end

    // weighted channel sums
    always_comb
    begin
        c0 = upper_a_reg ? cfg.color_mid : cfg.color_low;
        c1 = upper_a_reg ? cfg.color_high : cfg.color_mid;
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            sum_b_next[ch] =
                WSUM_W'(c0[(NCHAN - 1 - ch) * CHAN_W +: CHAN_W]) * WSUM_W'(w0_a_reg) +
                WSUM_W'(c1[(NCHAN - 1 - ch) * CHAN_W +: CHAN_W]) * WSUM_W'(w1_a_reg);
        end
    end

    // divide each sum by steps minus one, four quotient bits per stage
    always_comb
    begin
        logic [WSUM_W-1:0] rem;
        logic [WSUM_W-1:0] trial;
        logic [CHAN_W-1:0] q;
        for (int s = 0; s < CSTAGES; s++)
        begin
            if (s == 0)
            begin
                cv_next[s] = vb_reg;
                ck_next[s] = kb_reg;
            end
            else
            begin
                cv_next[s] = cv_reg[s-1];
                ck_next[s] = ck_reg[s-1];
            end
            for (int ch = 0; ch < NCHAN; ch++)
            begin
                if (s == 0)
                begin
                    rem = sum_b_reg[ch];
                    q   = '0;
                end
                else
                begin
                    rem = crem_reg[s-1][ch];
                    q   = cquo_reg[s-1][ch];
                end
                for (int i = 0; i < CBITS; i++)
                begin
                    if (s * CBITS + i < CHAN_W)
                    begin
                        trial = WSUM_W'(cfg.steps_m1) << (CHAN_W - 1 - s * CBITS - i);
                        if (rem >= trial)
                        begin
                            rem = rem - trial;
                            q   = {q[CHAN_W-2:0], 1'b1};
                        end
                        else
                        begin
                            q = {q[CHAN_W-2:0], 1'b0};
                        end
                    end
                end
                crem_next[s][ch] = rem;
                cquo_next[s][ch] = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int s = 0; s < CSTAGES; s++)
                cv_reg[s] <= 1'b0;
        end
        else
        begin
            va_reg <= quo.valid;
            vb_reg <= va_reg;
            for (int s = 0; s < CSTAGES; s++)
                cv_reg[s] <= cv_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        ka_reg      <= k_a;
        upper_a_reg <= upper;
        w1_a_reg    <= w1;
        w0_a_reg    <= cfg.steps_m1 - w1;
        kb_reg      <= ka_reg;
        for (int ch = 0; ch < NCHAN; ch++)
            sum_b_reg[ch] <= sum_b_next[ch];
        for (int s = 0; s < CSTAGES; s++)
        begin
            ck_reg[s] <= ck_next[s];
            for (int ch = 0; ch < NCHAN; ch++)
            begin
                crem_reg[s][ch] <= crem_next[s][ch];
                cquo_reg[s][ch] <= cquo_next[s][ch];
            end
        end
    end

    assign done       = cv_reg[CSTAGES-1];
    assign red        = cquo_reg[CSTAGES-1][0];
    assign green      = cquo_reg[CSTAGES-1][1];
    assign blue       = cquo_reg[CSTAGES-1][2];
    assign step_index = STEP_OUT_W'(ck_reg[CSTAGES-1]);

endmodule

// ===== hw/rtl/stepped_three_color_map.sv =====
// ----------------------------------------------------------------------------
// stepped_three_color_map
// stepped three-point diverging color map, one sample word per clock
// ----------------------------------------------------------------------------
// usage
//   input: a sample word is taken at each rising edge with start high; busy
//   is always low, so a new sample may be given in every cycle
//   output: done is high for one cycle with red, green, blue and step_index;
//   the receiver takes the word in that cycle and cannot hold it off
//   pipeline: the word passes four position stages, three divider stages for
//   the step index, the weight and sum stages and two channel divider stages
//   before done is raised
//   throughput: one word per clock, set by the fully pipelined dividers
//   configuration: wr_en, wr_index and wr_data write one register per edge;
//   write only while no sample is in flight
//   reset: rst_n clears the pipeline valid bits and loads the register
//   defaults; results of words in flight at reset are dropped
// ----------------------------------------------------------------------------
module stepped_three_color_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [scm_pkg::SW-1:0]   sample,
    input  logic                            wr_en,
    input  logic [scm_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]  wr_data,
    output logic                            done,
    output logic [scm_pkg::CHAN_W-1:0]      red,
    output logic [scm_pkg::CHAN_W-1:0]      green,
    output logic [scm_pkg::CHAN_W-1:0]      blue,
    output logic [scm_pkg::STEP_OUT_W-1:0]  step_index
);
    import scm_pkg::*;

    cfg_t cfg;
    pos_t pos;
    quo_t quo;
    logic in_valid;

    assign busy     = 1'b0;
    assign in_valid = start & ~busy;

    scm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    scm_pos u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sample   (sample),
        .cfg      (cfg),
        .pos      (pos)
    );

    scm_qdiv u_qdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .pos   (pos),
        .quo   (quo)
    );

    scm_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .quo        (quo),
        .cfg        (cfg),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .step_index (step_index)
    );

endmodule

// ===== tb/stepped_three_color_map_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepped_three_color_map_tb
// self-checking bench for the stepped three-point color map: directed table
// of extremes, clamping, unordered limits, empty segments and step counts,
// then random phases each with a fresh register setting, all words checked
// field by field against a typed word or a local integer model of the map
// ----------------------------------------------------------------------------
module stepped_three_color_map_tb;

    import scm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_PHASES      = 10;
    localparam int PHASE_ITEMS   = 75;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [STEP_OUT_W-1:0] step_idx;
    } pixel_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [REG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        pixel_t                pix;
    } stim_row_t;

    localparam int N_ROWS = 39;

    // typed words are red, green, blue, step
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_SAMPLE, REG_UNUSED,     24'h008000, 1'b1, 32'h0000FF00},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000000, 1'b1, 32'h0000FF00},
        '{ROW_SAMPLE, REG_UNUSED,     24'h007FFF, 1'b1, 32'hFF00000F},
        '{ROW_SAMPLE, REG_UNUSED,     24'h004000, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h003FFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h005555, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h00AAAA, 1'b1, 32'h0000FF00},
        '{ROW_WRITE,  REG_STEP_COUNT, 24'h000000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_LOW,  24'h008000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_MID,  24'h000000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_HIGH, 24'h007FFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h008000, 1'b1, 32'h0000FF00},
        '{ROW_SAMPLE, REG_UNUSED,     24'h007FFF, 1'b1, 32'hFF000001},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_COUNT, 24'h0001FF, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_COLOR_LOW,  24'h000000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_COLOR_MID,  24'hFFFFFF, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_COLOR_HIGH, 24'h000000, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h007FFF, 1'b1, 32'h000000FF},
        '{ROW_SAMPLE, REG_UNUSED,     24'h008000, 1'b1, 32'h00000000},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000001, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h00FFFF, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_LOW,  24'h0003E8, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_MID,  24'h00FC18, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_HIGH, 24'h0001F4, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_COUNT, 24'h000001, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000000, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h007FFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h008000, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_LOW,  24'h00FFFB, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_MID,  24'h000064, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_VALUE_HIGH, 24'h000064, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_COUNT, 24'h000101, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_COLOR_MID,  24'hA05A0F, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000064, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h0000C8, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h00FF9C, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_UNUSED,     24'hFFFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, REG_UNUSED,     24'h000032, 1'b0, 32'h0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [SW-1:0]      sample;
    logic                      wr_en;
    logic [REG_IDX_W-1:0]      wr_index;
    logic [CFG_DATA_W-1:0]     wr_data;
    logic                      done;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic [STEP_OUT_W-1:0]     step_index;

    // local copy of the register file
    logic signed [SW-1:0]      lim_low  = VALUE_LOW_RST;
    logic signed [SW-1:0]      lim_mid  = VALUE_MID_RST;
    logic signed [SW-1:0]      lim_high = VALUE_HIGH_RST;
    logic [COLOR_W-1:0]        col_low  = COLOR_LOW_RST;
    logic [COLOR_W-1:0]        col_mid  = COLOR_MID_RST;
    logic [COLOR_W-1:0]        col_high = COLOR_HIGH_RST;
    logic [STEP_CFG_W-1:0]     step_reg = STEP_COUNT_RST;

    pixel_t                    expected_pixels [$];
    int                        mismatch_count = 0;
    int                        cycle_count = 0;

    stepped_three_color_map dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .step_index (step_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] c0,
                                                        input logic [CHAN_W-1:0] c1,
                                                        input longint w0, input longint w1,
                                                        input longint s1);
        return CHAN_W'((longint'(c0) * w0 + longint'(c1) * w1) / s1);
    endfunction

    function automatic pixel_t map_sample(input logic signed [SW-1:0] value);
        longint lo, mi, hi, x, a, b, n, d, seg, steps, s1, k, w0, w1;
        logic [COLOR_W-1:0] c0, c1;
        pixel_t pix;
        lo = longint'(lim_low);
        mi = longint'(lim_mid);
        hi = longint'(lim_high);
        x = longint'(value);
        steps = longint'(step_reg);
        if (steps < 2)
            steps = 2;
        if (steps > MAX_STEPS)
            steps = MAX_STEPS;
        s1 = steps - 1;
        if (x < lo)
            x = lo;
        else if (hi < x)
            x = hi;
        if (x < mi)
        begin
            seg = 0; a = lo; b = mi;
        end
        else
        begin
            seg = 1; a = mi; b = hi;
        end
        d = b - a;
        n = x - a;
        // empty segment
        if (d <= 0)
        begin
            n = 0; d = 1;
        end
        if (n < 0)
            n = 0;
        if (n > d)
            n = d;
        k = ((seg * d + n) * steps) / (2 * d);
        if (k > s1)
            k = s1;
        if (2 * k < s1)
        begin
            c0 = col_low; c1 = col_mid; w1 = 2 * k;
        end
        else
        begin
            c0 = col_mid; c1 = col_high; w1 = 2 * k - s1;
        end
        w0 = s1 - w1;
        pix.red      = blend_channel(c0[23:16], c1[23:16], w0, w1, s1);
        pix.green    = blend_channel(c0[15:8], c1[15:8], w0, w1, s1);
        pix.blue     = blend_channel(c0[7:0], c1[7:0], w0, w1, s1);
        pix.step_idx = STEP_OUT_W'(k);
        return pix;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        int lo_i, hi_i;
        lo_i = int'(lim_low);
        hi_i = int'(lim_high);
        case ($urandom_range(0, 9)) inside
            [0:2]: return SW'($urandom);
            3: return lim_low + SW'($urandom_range(0, 4)) - SW'(2);
            4: return lim_mid + SW'($urandom_range(0, 4)) - SW'(2);
            5: return lim_high + SW'($urandom_range(0, 4)) - SW'(2);
            6: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:
            begin
                if (lo_i < hi_i)
                    return SW'(lo_i + int'($urandom_range(0, hi_i - lo_i)));
                return SW'($urandom);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // leaves wr_en high so that writes may follow back to back
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        unique case (idx)
            REG_VALUE_LOW:  lim_low  = data[SW-1:0];
            REG_VALUE_MID:  lim_mid  = data[SW-1:0];
            REG_VALUE_HIGH: lim_high = data[SW-1:0];
            REG_COLOR_LOW:  col_low  = data[COLOR_W-1:0];
            REG_COLOR_MID:  col_mid  = data[COLOR_W-1:0];
            REG_COLOR_HIGH: col_high = data[COLOR_W-1:0];
            REG_STEP_COUNT: step_reg = data[STEP_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // leaves start high so that the next word may follow at once
    task automatic send_sample(input logic signed [SW-1:0] value, input pixel_t want);
        start  <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_pixels.push_back(want);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle_pipeline();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_phase(input int phase);
        logic signed [SW-1:0]  v0, v1, v2, t;
        logic [STEP_CFG_W-1:0] sc;
        v0 = SW'($urandom);
        v1 = SW'($urandom);
        v2 = SW'($urandom);
        if (phase % 4 != 2)
        begin
            if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
            if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
            if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
        end
        case (phase % 4)
            0: sc = STEP_CFG_W'($urandom_range(2, 20));
            1:
            begin
                v0 = 16'sh8000;
                v2 = 16'sh7FFF;
                sc = $urandom_range(0, 1) ? 9'd256 : 9'd255;
            end
            2: sc = STEP_CFG_W'($urandom);
            default:
            begin
                // collapsed segment, step count from 0 to 3 or from 257 to 511
                if ($urandom_range(0, 1))
                    v1 = v2;
                else
                    v1 = v0;
                sc = STEP_CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                      : $urandom_range(257, 511));
            end
        endcase
        settle_pipeline();
        write_reg(REG_VALUE_LOW, CFG_DATA_W'(v0));
        write_reg(REG_VALUE_MID, CFG_DATA_W'(v1));
        write_reg(REG_VALUE_HIGH, CFG_DATA_W'(v2));
        if (phase % 4 == 1)
        begin
            write_reg(REG_COLOR_LOW, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
            write_reg(REG_COLOR_MID, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
            write_reg(REG_COLOR_HIGH, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
        end
        else
        begin
            write_reg(REG_COLOR_LOW, CFG_DATA_W'($urandom));
            write_reg(REG_COLOR_MID, CFG_DATA_W'($urandom));
            write_reg(REG_COLOR_HIGH, CFG_DATA_W'($urandom));
        end
        write_reg(REG_STEP_COUNT, CFG_DATA_W'(sc));
        wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("word with nothing expected", {red, green, blue, step_index},
                                32'd0);
            else
            begin
                want = expected_pixels.pop_front();
                if (red !== want.red)
                    report_mismatch("red", 32'(red), 32'(want.red));
                if (green !== want.green)
                    report_mismatch("green", 32'(green), 32'(want.green));
                if (blue !== want.blue)
                    report_mismatch("blue", 32'(blue), 32'(want.blue));
                if (step_index !== want.step_idx)
                    report_mismatch("step_index", 32'(step_index), 32'(want.step_idx));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        stim_row_t            row;
        logic signed [SW-1:0] value;
        bit                   writing;
        bit                   idle_on;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        sample   <= '0;
        wr_en    <= 1'b0;
        wr_index <= REG_VALUE_LOW;
        wr_data  <= '0;
        writing  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    settle_pipeline();
                    writing = 1'b1;
                end
                write_reg(row.idx, row.data);
            end
            else
            begin
                if (writing)
                begin
                    wr_en <= 1'b0;
                    writing = 1'b0;
                end
                value = row.data[SW-1:0];
                send_sample(value, row.typed ? row.pix : map_sample(value));
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            program_phase(phase);
            idle_on = (phase != N_PHASES - 1) && (phase % 3 != 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                value = pick_sample();
                send_sample(value, map_sample(value));
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause_sender(int'($urandom_range(1, 3)));
            end
        end

        settle_pipeline();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
